/* design/hhc_pkg.sv */
// Package for the humidifier hysteresis controller: widths, codes and register values.
package hhc_pkg;

  // Field and register widths
  localparam int unsigned HumW   = 10;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned CauseW = 3;
  localparam int unsigned IdxW   = 3;
  localparam int unsigned DefW   = HumW + 2;

  // Input and output tdata widths (padded to whole bytes)
  localparam int unsigned InDataW  = 16;
  localparam int unsigned OutDataW = 8;

  // Item kinds carried in tuser
  localparam logic FuncTick   = 1'b0;
  localparam logic FuncSample = 1'b1;

  // Configuration register indexes
  localparam logic [IdxW-1:0] RegTarget    = 3'd0;
  localparam logic [IdxW-1:0] RegSafeMin   = 3'd1;
  localparam logic [IdxW-1:0] RegSafeMax   = 3'd2;
  localparam logic [IdxW-1:0] RegOnMargin  = 3'd3;
  localparam logic [IdxW-1:0] RegMinOn     = 3'd4;
  localparam logic [IdxW-1:0] RegMinOff    = 3'd5;
  localparam logic [IdxW-1:0] RegMaxOn     = 3'd6;

  // Register reset values
  localparam logic [HumW-1:0]  TargetRst   = 10'd500;
  localparam logic [HumW-1:0]  SafeMinRst  = 10'd100;
  localparam logic [HumW-1:0]  SafeMaxRst  = 10'd950;
  localparam logic [HumW-1:0]  OnMarginRst = 10'd50;
  localparam logic [TimeW-1:0] MinOnRst    = 32'd30000;
  localparam logic [TimeW-1:0] MinOffRst   = 32'd60000;
  localparam logic [TimeW-1:0] MaxOnRst    = 32'd600000;

  // Fixed limits: humidity values in tenths of a percent, and the counter saturation value
  localparam logic [HumW-1:0]         TargetLow  = 10'd200;
  localparam logic [HumW-1:0]         TargetHigh = 10'd800;
  localparam logic signed [DefW-1:0]  OffDeficit = 12'sd10;
  localparam logic [TimeW-1:0]        TimeSat    = {TimeW{1'b1}};

  // Reported cause of each result
  typedef enum logic [CauseW-1:0] {
    CauseHold     = 3'd0,
    CauseDisabled = 3'd1,
    CauseInvalid  = 3'd2,
    CauseUnsafe   = 3'd3,
    CauseReached  = 3'd4,
    CauseMaxTime  = 3'd5,
    CauseOn       = 3'd6,
    CauseTick     = 3'd7
  } cause_e;

  // One request after the input register
  typedef struct packed {
    logic            func;
    logic            emergency_active;
    logic            system_enabled;
    logic            humidity_valid;
    logic [HumW-1:0] humidity;
  } req_t;

  // One result
  typedef struct packed {
    cause_e cause;
    logic   switched;
    logic   humidifier_on;
  } res_t;

endpackage

/* design/humidifier_hysteresis_control_top.sv */
// Humidifier on/off controller with hysteresis and minimum on/off times.
//
// Usage:
//   Requests arrive on the s_axis channel. tuser carries the kind: 0 is a one
//   millisecond tick, 1 is a humidity sample whose reading and flags sit in
//   tdata. Each request yields exactly one result on m_axis: drive level,
//   a switched flag and a cause code.
//   Registers are written through cfg_we_i / cfg_idx_i / cfg_wdata_i while
//   the block is idle; an index past the last register is ignored.
// Pipeline and throughput:
//   A request accepted on s_axis is captured in the input register, decided
//   combinationally and shown on m_axis once the result register loads it.
//   One request per cycle is sustained while m_axis_tready is high; a single
//   pass of compares and 32-bit counter updates lies between the two regs.
// Reset:
//   The humidifier is off, both elapsed counters are saturated and all
//   registers return to their default values; no result is pending.
// Stall:
//   While m_axis_tready is low the result holds; the input register still
//   takes one more request, after which s_axis_tready drops.
module humidifier_hysteresis_control_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Configuration write port
  input  logic                        cfg_we_i,
  input  logic [hhc_pkg::IdxW-1:0]    cfg_idx_i,
  input  logic [hhc_pkg::TimeW-1:0]   cfg_wdata_i,
  // Request channel
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // tdata: humidity[9:0], humidity_valid[10], system_enabled[11],
  //        emergency_active[12], zero[15:13]
  input  logic [hhc_pkg::InDataW-1:0] s_axis_tdata,
  // tuser: func[0]
  input  logic                        s_axis_tuser,
  // Result channel
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // tdata: humidifier_on[0], switched[1], cause[4:2], zero[7:5]
  output logic [hhc_pkg::OutDataW-1:0] m_axis_tdata
);
  import hhc_pkg::*;

  // Configuration registers
  logic [HumW-1:0]  target_q, safe_min_q, safe_max_q, on_margin_q;
  logic [TimeW-1:0] min_on_q, min_off_q, max_on_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q    <= TargetRst;
      safe_min_q  <= SafeMinRst;
      safe_max_q  <= SafeMaxRst;
      on_margin_q <= OnMarginRst;
      min_on_q    <= MinOnRst;
      min_off_q   <= MinOffRst;
      max_on_q    <= MaxOnRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegTarget:   target_q    <= cfg_wdata_i[HumW-1:0];
        RegSafeMin:  safe_min_q  <= cfg_wdata_i[HumW-1:0];
        RegSafeMax:  safe_max_q  <= cfg_wdata_i[HumW-1:0];
        RegOnMargin: on_margin_q <= cfg_wdata_i[HumW-1:0];
        RegMinOn:    min_on_q    <= cfg_wdata_i;
        RegMinOff:   min_off_q   <= cfg_wdata_i;
        RegMaxOn:    max_on_q    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Pipeline handshake
  logic in_valid_q, out_valid_q;
  logic advance, in_accept;
  req_t req_q;
  res_t res_q, res_d;

  assign advance       = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !in_valid_q || advance;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_accept) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  // Input register
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      req_q.func             <= s_axis_tuser;
      req_q.humidity         <= s_axis_tdata[HumW-1:0];
      req_q.humidity_valid   <= s_axis_tdata[HumW];
      req_q.system_enabled   <= s_axis_tdata[HumW+1];
      req_q.emergency_active <= s_axis_tdata[HumW+2];
    end
  end

  // Controller state
  logic             running_q, running_d;
  logic [TimeW-1:0] on_el_q, on_el_d, off_el_q, off_el_d;
  logic             load;

  assign load = advance && in_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q <= 1'b0;
      on_el_q   <= TimeSat;
      off_el_q  <= TimeSat;
    end else if (load) begin
      running_q <= running_d;
      on_el_q   <= on_el_d;
      off_el_q  <= off_el_d;
    end
  end

  // Decision logic
  logic signed [DefW-1:0] deficit;
  logic signed [DefW-1:0] margin_s;
  logic                   unsafe;

  assign deficit  = $signed({2'b00, target_q}) - $signed({2'b00, req_q.humidity});
  assign margin_s = $signed({2'b00, on_margin_q});
  assign unsafe   = (req_q.humidity < safe_min_q) || (req_q.humidity > safe_max_q) ||
                    (target_q < TargetLow) || (target_q > TargetHigh);

  always_comb begin
    running_d = running_q;
    on_el_d   = on_el_q;
    off_el_d  = off_el_q;
    res_d.switched = 1'b0;
    res_d.cause    = CauseHold;
    if (req_q.func == FuncTick) begin
      // saturating millisecond counters
      on_el_d     = (on_el_q == TimeSat) ? on_el_q : on_el_q + 1'b1;
      off_el_d    = (off_el_q == TimeSat) ? off_el_q : off_el_q + 1'b1;
      res_d.cause = CauseTick;
    end else if (!req_q.system_enabled || req_q.emergency_active) begin
      running_d      = 1'b0;
      res_d.switched = running_q;
      res_d.cause    = CauseDisabled;
    end else if (!req_q.humidity_valid) begin
      running_d      = 1'b0;
      res_d.switched = running_q;
      res_d.cause    = CauseInvalid;
    end else if (unsafe) begin
      running_d      = 1'b0;
      res_d.switched = running_q;
      res_d.cause    = CauseUnsafe;
    end else if (running_q) begin
      // turn-off only after the minimum work time
      if (on_el_q >= min_on_q) begin
        if (deficit <= OffDeficit) begin
          running_d      = 1'b0;
          off_el_d       = '0;
          res_d.switched = 1'b1;
          res_d.cause    = CauseReached;
        end else if (on_el_q > max_on_q) begin
          running_d      = 1'b0;
          off_el_d       = '0;
          res_d.switched = 1'b1;
          res_d.cause    = CauseMaxTime;
        end
      end
    end else if ((off_el_q >= min_off_q) && (deficit > margin_s)) begin
      running_d      = 1'b1;
      on_el_d        = '0;
      res_d.switched = 1'b1;
      res_d.cause    = CauseOn;
    end
    res_d.humidifier_on = running_d;
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OutDataW-CauseW-2){1'b0}}, res_q.cause, res_q.switched,
                          res_q.humidifier_on};

  // Checks
  a_drive_matches_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> (res_q.humidifier_on == running_q))
    else $error("result drive level differs from controller state");

  a_tick_no_switch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.cause == CauseTick) |-> !res_q.switched)
    else $error("tick request changed the drive level");

  a_on_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.cause == CauseOn) |-> (res_q.switched && res_q.humidifier_on))
    else $error("switch-on result without drive on");

  a_off_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (res_q.cause == CauseReached || res_q.cause == CauseMaxTime)) |->
    (res_q.switched && !res_q.humidifier_on))
    else $error("normal turn-off result with drive still on");

  a_off_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && running_q && !running_d && res_d.cause != CauseDisabled &&
     res_d.cause != CauseInvalid && res_d.cause != CauseUnsafe) |=> (off_el_q == '0))
    else $error("off counter not restarted on normal turn-off");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready) |=> $stable(res_q))
    else $error("result changed while stalled");

endmodule
